/* rtl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the steering angle command limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned ID_W       = 11;
  localparam int unsigned STEP_W     = 15;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PAYLOAD_W  = 64;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [INTERVAL_W-1:0] SEND_INTERVAL_RST      = 16'd20;
  localparam logic [INTERVAL_W-1:0] KEEPALIVE_INTERVAL_RST = 16'd100;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_ENTRY = 2'd1,
    ACT_EXIT  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATUS_ID    = 3'd0,
    REG_COMMAND_ID   = 3'd1,
    REG_MAX_STEP     = 3'd2,
    REG_LEFT_LIMIT   = 3'd3,
    REG_RIGHT_LIMIT  = 3'd4,
    REG_MAX_VELOCITY = 3'd5,
    REG_SEND_IVL     = 3'd6,
    REG_KEEPALIVE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]       status_frame_id;
    logic [ID_W-1:0]       command_frame_id;
    logic [STEP_W-1:0]     max_step;
    logic [ANGLE_W-1:0]    left_limit;
    logic [ANGLE_W-1:0]    right_limit;
    logic [ANGLE_W-1:0]    max_velocity;
    logic [INTERVAL_W-1:0] send_interval;
    logic [INTERVAL_W-1:0] keepalive_interval;
  } cfg_t;

  typedef struct packed {
    action_t           action;
    logic [TIME_W-1:0] timestamp_ms;
    logic [ID_W-1:0]   frame_id;
    logic [7:0]        frame_byte0;
    logic [7:0]        frame_byte1;
    logic [7:0]        frame_byte2;
    logic              tx_ready;
  } item_t;

  typedef struct packed {
    logic                 tx_valid;
    logic [PAYLOAD_W-1:0] frame_payload;
    logic                 control_on;
    logic                 exit_retry;
  } result_t;

endpackage

`default_nettype wire

/* rtl/sacl_cfg.sv */
// ----------------------------------------------------------------------------
// sacl_cfg
// Configuration register file, written through an index/data request port.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data,
  output sacl_pkg::cfg_t                           cfg
);

  sacl_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.status_frame_id    <= '0;
      regs.command_frame_id   <= '0;
      regs.max_step           <= '0;
      regs.left_limit         <= '0;
      regs.right_limit        <= '0;
      regs.max_velocity       <= '0;
      regs.send_interval      <= sacl_pkg::SEND_INTERVAL_RST;
      regs.keepalive_interval <= sacl_pkg::KEEPALIVE_INTERVAL_RST;
    end else if (cfg_valid) begin
      case (sacl_pkg::cfg_idx_t'(cfg_index))
        sacl_pkg::REG_STATUS_ID:    regs.status_frame_id    <= cfg_data[sacl_pkg::ID_W-1:0];
        sacl_pkg::REG_COMMAND_ID:   regs.command_frame_id   <= cfg_data[sacl_pkg::ID_W-1:0];
        sacl_pkg::REG_MAX_STEP:     regs.max_step           <= cfg_data[sacl_pkg::STEP_W-1:0];
        sacl_pkg::REG_LEFT_LIMIT:   regs.left_limit         <= cfg_data;
        sacl_pkg::REG_RIGHT_LIMIT:  regs.right_limit        <= cfg_data;
        sacl_pkg::REG_MAX_VELOCITY: regs.max_velocity       <= cfg_data;
        sacl_pkg::REG_SEND_IVL:     regs.send_interval      <= cfg_data;
        sacl_pkg::REG_KEEPALIVE:    regs.keepalive_interval <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/sacl_engine.sv */
// ----------------------------------------------------------------------------
// sacl_engine
// Gateway state and per-request update: angle tracking, slew limit, clamp,
// send timing, exit retry and keep-alive.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sacl_pkg::cfg_t    cfg,
  input  wire logic              fire,
  input  wire sacl_pkg::item_t   item,
  output sacl_pkg::result_t      result
);

  localparam int unsigned AW = sacl_pkg::ANGLE_W;
  localparam int unsigned TW = sacl_pkg::TIME_W;

  logic [AW-1:0] measured_angle,  measured_angle_next;
  logic [AW-1:0] previous_target, previous_target_next;
  logic          command_enable,  command_enable_next;
  logic [AW-1:0] command_angle,   command_angle_next;
  logic [TW-1:0] last_send_time,  last_send_time_next;
  logic          control_flag,    control_flag_next;
  logic          exit_pending,    exit_pending_next;

  logic [AW-1:0] rx_angle;
  logic [AW-1:0] tgt;
  logic [AW-1:0] diff;
  logic [AW:0]   step_ext;
  logic [AW-1:0] slewed;
  logic [AW-1:0] limited;
  logic [TW-1:0] elapsed;
  logic          send_ok;
  logic          keep_ok;
  logic          exit_sent;
  logic          sent;

  assign rx_angle = {item.frame_byte1, item.frame_byte2};
  assign elapsed  = item.timestamp_ms - last_send_time;
  assign send_ok  = (elapsed > {{(TW-sacl_pkg::INTERVAL_W){1'b0}}, cfg.send_interval})
                    && item.tx_ready;
  assign keep_ok  = elapsed > {{(TW-sacl_pkg::INTERVAL_W){1'b0}}, cfg.keepalive_interval};

  // slew limit around the measured angle, then clamp to the end stops
  always_comb begin
    case (item.action)
      sacl_pkg::ACT_FRAME: tgt = rx_angle;
      sacl_pkg::ACT_ENTRY: tgt = measured_angle;
      default:             tgt = previous_target;
    endcase
    diff     = tgt - measured_angle;
    step_ext = {2'b00, cfg.max_step};
    if ($signed({diff[AW-1], diff}) > $signed(step_ext)) begin
      slewed = measured_angle + step_ext[AW-1:0];
    end else if ($signed({diff[AW-1], diff}) < -$signed(step_ext)) begin
      slewed = measured_angle - step_ext[AW-1:0];
    end else begin
      slewed = tgt;
    end
    if ($signed(slewed) > $signed(cfg.left_limit)) begin
      limited = cfg.left_limit;
    end else if ($signed(slewed) < $signed(cfg.right_limit)) begin
      limited = cfg.right_limit;
    end else begin
      limited = slewed;
    end
  end

  always_comb begin
    measured_angle_next  = measured_angle;
    previous_target_next = previous_target;
    command_enable_next  = command_enable;
    command_angle_next   = command_angle;
    control_flag_next    = control_flag;
    exit_pending_next    = exit_pending;
    exit_sent            = 1'b0;
    sent                 = 1'b0;
    case (item.action)
      sacl_pkg::ACT_FRAME: begin
        if (item.frame_id == cfg.status_frame_id) begin
          measured_angle_next = rx_angle;
        end else if (item.frame_id == cfg.command_frame_id && control_flag) begin
          command_enable_next  = item.frame_byte0[0];
          command_angle_next   = limited;
          previous_target_next = rx_angle;
          sent                 = send_ok;
        end
      end
      sacl_pkg::ACT_ENTRY: begin
        control_flag_next   = 1'b1;
        command_enable_next = 1'b1;
        command_angle_next  = limited;
      end
      sacl_pkg::ACT_EXIT: begin
        control_flag_next   = 1'b0;
        command_enable_next = 1'b0;
        sent                = send_ok;
        exit_pending_next   = !send_ok;
      end
      sacl_pkg::ACT_TICK: begin
        // retry a pending exit first; it drops control
        if (exit_pending) begin
          control_flag_next   = 1'b0;
          command_enable_next = 1'b0;
          exit_sent           = send_ok;
          exit_pending_next   = !send_ok;
        end
        if (!exit_pending && control_flag && elapsed >
            {{(TW-sacl_pkg::INTERVAL_W){1'b0}}, cfg.send_interval}) begin
          command_enable_next = 1'b1;
          command_angle_next  = limited;
          sent                = send_ok;
        end else if (!exit_sent && keep_ok) begin
          command_enable_next = 1'b0;
          sent                = send_ok;
        end else begin
          sent                = exit_sent;
        end
      end
      default: ;
    endcase
    last_send_time_next = sent ? item.timestamp_ms : last_send_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measured_angle  <= '0;
      previous_target <= '0;
      command_enable  <= 1'b0;
      command_angle   <= '0;
      last_send_time  <= '0;
      control_flag    <= 1'b0;
      exit_pending    <= 1'b0;
    end else if (fire) begin
      measured_angle  <= measured_angle_next;
      previous_target <= previous_target_next;
      command_enable  <= command_enable_next;
      command_angle   <= command_angle_next;
      last_send_time  <= last_send_time_next;
      control_flag    <= control_flag_next;
      exit_pending    <= exit_pending_next;
    end
  end

  assign result.tx_valid      = sent;
  assign result.frame_payload = {7'd0, command_enable_next, command_angle_next,
                                 cfg.max_velocity, 24'd0};
  assign result.control_on    = control_flag_next;
  assign result.exit_retry    = exit_pending_next;

  // with control off the held frame always carries enable low
  a_disabled_frame: assert property (@(posedge clk) disable iff (rst)
    !control_flag |-> !command_enable)
    else $error("command enable set while control is off");

  a_send_stamps_time: assert property (@(posedge clk) disable iff (rst)
    fire && sent |=> last_send_time == $past(item.timestamp_ms))
    else $error("send did not record its timestamp");

  a_entry_enables: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == sacl_pkg::ACT_ENTRY |=> control_flag && command_enable)
    else $error("control entry did not enable control");

endmodule

`default_nettype wire

/* rtl/steering_angle_command_limiter.sv */
// ----------------------------------------------------------------------------
// steering_angle_command_limiter
// Steering command gateway with slew-limited, clamped target angle.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one event (received frame, control
// entry, control exit or watchdog tick) and gives exactly one result on the
// master stream: a transmit flag, the held 8-byte command frame, and the
// control and exit-retry flags after the event. A request is registered, the
// whole update runs as compare-and-select logic into the result register, so
// one request per cycle is taken unless m_tready stalls; a request passes the
// input and result registers. Configuration writes are taken at any time with
// cfg_ready held high and should only be issued while no request is in flight.
`default_nettype none

module steering_angle_command_limiter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // timestamp_ms, frame_id, frame_byte0, frame_byte1, frame_byte2, tx_ready
  input  wire logic [sacl_pkg::IN_DATA_W-1:0]      s_tdata,
  // action
  input  wire logic [sacl_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // tx_valid, frame_payload, control_on, exit_retry
  output logic [sacl_pkg::OUT_DATA_W-1:0]          m_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sacl_pkg::cfg_t    cfg;
  sacl_pkg::item_t   in_item;
  sacl_pkg::result_t result;
  sacl_pkg::result_t out_res;
  logic              in_valid;
  logic              advance;
  logic              s_fire;

  sacl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.action       <= sacl_pkg::action_t'(s_tuser);
      in_item.timestamp_ms <= s_tdata[31:0];
      in_item.frame_id     <= s_tdata[42:32];
      in_item.frame_byte0  <= s_tdata[50:43];
      in_item.frame_byte1  <= s_tdata[58:51];
      in_item.frame_byte2  <= s_tdata[66:59];
      in_item.tx_ready     <= s_tdata[67];
    end
  end

  sacl_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tdata = {5'd0, out_res.exit_retry, out_res.control_on,
                    out_res.frame_payload, out_res.tx_valid};

  // an empty result slot never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
